// ----- rtl/gwm_pkg.sv -----
package gwm_pkg;

	// Store depth and the widths that follow from it.
	localparam int MAX_LEN = 32;
	localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);

	// Pattern wildcards.
	localparam logic [7:0] CH_ANY  = 8'h3F;
	localparam logic [7:0] CH_STAR = 8'h2A;

	typedef enum logic [1:0] {
		OP_PAT_APPEND = 2'd0,
		OP_PAT_CLEAR  = 2'd1,
		OP_SUB_APPEND = 2'd2,
		OP_MATCH      = 2'd3
	} op_t;

	// Microprogram steps.
	typedef enum logic [1:0] {
		ST_LOOP    = 2'd0,
		ST_MAIN    = 2'd1,
		ST_TAIL_RD = 2'd2,
		ST_TAIL    = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_MAIN = 2'd1,
		ACT_TAIL = 2'd2
	} act_t;

	typedef enum logic {
		BR_ALWAYS  = 1'b0,
		BR_SUB_END = 1'b1
	} br_t;

	// One control word: read strobe, datapath action, branch test and targets.
	typedef struct packed {
		logic  rd;
		act_t  act;
		br_t   br;
		step_t tgt;
		step_t nxt;
	} ctrl_t;

	function automatic ctrl_t ucode_rom(input step_t step);
		ctrl_t w;
		case (step)
			ST_LOOP:    w = '{rd: 1'b1, act: ACT_NONE, br: BR_SUB_END,
			                  tgt: ST_TAIL_RD, nxt: ST_MAIN};
			ST_MAIN:    w = '{rd: 1'b0, act: ACT_MAIN, br: BR_ALWAYS,
			                  tgt: ST_LOOP, nxt: ST_LOOP};
			ST_TAIL_RD: w = '{rd: 1'b1, act: ACT_NONE, br: BR_ALWAYS,
			                  tgt: ST_TAIL, nxt: ST_TAIL};
			ST_TAIL:    w = '{rd: 1'b0, act: ACT_TAIL, br: BR_ALWAYS,
			                  tgt: ST_TAIL_RD, nxt: ST_TAIL_RD};
			default:    w = '{rd: 1'b0, act: ACT_NONE, br: BR_ALWAYS,
			                  tgt: ST_LOOP, nxt: ST_LOOP};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/wildcard_glob_matcher_core.sv -----
// Wildcard glob matcher. The block holds a pattern and a testee in two byte
// memories of MAX_LEN entries. Words with op 0 and 2 append a nonzero byte to
// the pattern or the testee, op 1 clears the pattern, and op 3 tests the whole
// testee against the whole pattern, where '?' matches any one byte and '*' any
// run of bytes; the match is greedy and backtracks to the most recent star
// only. Op 3 returns one word with matched and overflow (a byte was lost to a
// full store) and then empties the testee; the pattern is kept. Ops 0, 1 and 2
// never make the block busy. Op 3 runs a four-step microprogram from a small
// control ROM: each main-loop step (a compare of one pattern position against
// one testee position, or taking a star) is a registered memory read and then
// an evaluate. A failed compare with no star to fall back on ends the run right
// there. Otherwise the loop step finds the testee used up, each trailing star
// is read and skipped, and a final read and check of the pattern end follows.
// Each store has a single read port. A finished result sits in an output
// register; a further op 3 holds its last step until that register is free.
module wildcard_glob_matcher_core
	import gwm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       matched,
	output logic       overflow
);

	// Byte stores, one write and one registered read port each.
	logic [7:0] pmem [MAX_LEN];
	logic [7:0] smem [MAX_LEN];
	logic [7:0] prd_q;
	logic [7:0] srd_q;

	logic [CNT_W-1:0] pcnt_q, scnt_q;
	logic             ptrunc_q, strunc_q;

	// Matcher datapath.
	logic [CNT_W-1:0] p_q, s_q, star_p_q, star_s_q;
	logic             have_star_q;
	logic             ovf_q;

	// Sequencer.
	logic  busy_q, busy_d;
	step_t step_q, step_d;
	ctrl_t ctrl;

	logic out_valid_q, matched_q, overflow_q;

	logic       accept;
	op_t        op_in;
	logic       byte_nz;
	logic [7:0] pc;
	logic       is_star, hit, main_fail, finish, verdict, out_free, stall, br_true;

	assign op_in    = op_t'(op);
	assign accept   = in_valid && in_ready;
	assign byte_nz  = (byte_value != 8'd0);
	assign in_ready = !busy_q;

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign overflow  = overflow_q;

	always_comb begin
		ctrl = ucode_rom(step_q);
		// Positions at or past the pattern end read as zero.
		pc        = (p_q < pcnt_q) ? prd_q : 8'd0;
		is_star   = (pc == CH_STAR);
		hit       = (pc == CH_ANY) || ((pc != 8'd0) && (pc == srd_q));
		main_fail = !is_star && !hit && !have_star_q;
		finish    = ((ctrl.act == ACT_MAIN) && main_fail) ||
		            ((ctrl.act == ACT_TAIL) && !is_star);
		verdict   = (ctrl.act == ACT_TAIL) && (p_q >= pcnt_q);
		out_free  = !out_valid_q || out_ready;
		stall     = finish && !out_free;
		br_true   = (ctrl.br == BR_ALWAYS) || (s_q >= scnt_q);
	end

	// Step counter and conditional jumps.
	always_comb begin
		busy_d = busy_q;
		step_d = step_q;
		if (accept && (op_in == OP_MATCH)) begin
			busy_d = 1'b1;
			step_d = ST_LOOP;
		end else if (busy_q && !stall) begin
			if (finish) begin
				busy_d = 1'b0;
			end else begin
				step_d = br_true ? ctrl.tgt : ctrl.nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_LOOP;
		end else begin
			busy_q <= busy_d;
			step_q <= step_d;
		end
	end

	// Memory writes and reads.
	always_ff @(posedge clk) begin
		if (accept && (op_in == OP_PAT_APPEND) && byte_nz && (pcnt_q < CNT_W'(MAX_LEN))) begin
			pmem[pcnt_q[IDX_W-1:0]] <= byte_value;
		end
		if (accept && (op_in == OP_SUB_APPEND) && byte_nz && (scnt_q < CNT_W'(MAX_LEN))) begin
			smem[scnt_q[IDX_W-1:0]] <= byte_value;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && ctrl.rd) begin
			prd_q <= pmem[p_q[IDX_W-1:0]];
			srd_q <= smem[s_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q      <= '0;
			scnt_q      <= '0;
			ptrunc_q    <= 1'b0;
			strunc_q    <= 1'b0;
			p_q         <= '0;
			s_q         <= '0;
			star_p_q    <= '0;
			star_s_q    <= '0;
			have_star_q <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			matched_q   <= 1'b0;
			overflow_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				case (op_in)
					OP_PAT_APPEND: begin
						if (byte_nz) begin
							if (pcnt_q < CNT_W'(MAX_LEN)) begin
								pcnt_q <= pcnt_q + 1'b1;
							end else begin
								ptrunc_q <= 1'b1;
							end
						end
					end
					OP_PAT_CLEAR: begin
						pcnt_q   <= '0;
						ptrunc_q <= 1'b0;
					end
					OP_SUB_APPEND: begin
						if (byte_nz) begin
							if (scnt_q < CNT_W'(MAX_LEN)) begin
								scnt_q <= scnt_q + 1'b1;
							end else begin
								strunc_q <= 1'b1;
							end
						end
					end
					OP_MATCH: begin
						p_q         <= '0;
						s_q         <= '0;
						have_star_q <= 1'b0;
						ovf_q       <= ptrunc_q || strunc_q;
					end
					default: begin
					end
				endcase
			end

			if (busy_q && !stall) begin
				if (ctrl.act == ACT_MAIN) begin
					if (is_star) begin
						// Remember the star and first try it as an empty run.
						have_star_q <= 1'b1;
						star_p_q    <= p_q;
						star_s_q    <= s_q;
						p_q         <= p_q + 1'b1;
					end else if (hit) begin
						p_q <= p_q + 1'b1;
						s_q <= s_q + 1'b1;
					end else if (have_star_q) begin
						// Let the last star swallow one more testee byte.
						p_q      <= star_p_q + 1'b1;
						star_s_q <= star_s_q + 1'b1;
						s_q      <= star_s_q + 1'b1;
					end
				end
				if ((ctrl.act == ACT_TAIL) && is_star) begin
					p_q <= p_q + 1'b1;
				end
				if (finish) begin
					out_valid_q <= 1'b1;
					matched_q   <= verdict;
					overflow_q  <= ovf_q;
					scnt_q      <= '0;
					strunc_q    <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- rtl/gwm_checker.sv -----
module gwm_checker
	import gwm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] op,
	input logic       out_valid,
	input logic       out_ready,
	input logic       matched,
	input logic       overflow
);

	// A stalled result word keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(overflow))
		else $error("result word changed while stalled");

	// An accepted match op makes the block busy.
	a_match_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_MATCH) |=> !in_ready)
		else $error("ready after a match op was accepted");

	// Append and clear ops leave the block ready in the next cycle.
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op != OP_MATCH) |=> in_ready)
		else $error("load op left the block busy");

	// A new result only appears at the end of a match run.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a match run");

endmodule

bind wildcard_glob_matcher_core gwm_checker u_gwm_checker (.*);

// ----- tb/wildcard_glob_matcher_core_test.sv -----
module wildcard_glob_matcher_core_test;
	import gwm_pkg::*;

	// Cycles without any accepted word before the run is declared hung. A single
	// op 3 with heavy backtracking over two full stores is the longest wait, and
	// each side may also idle between words on top of that.
	localparam int HANG_LIMIT = 20000;
	// Nonignored input words in the random part.
	localparam int RANDOM_WORDS = 2000;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] op = 2'd0;
	logic [7:0] byte_value = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       matched;
	logic       overflow;

	// Local copy of the block's state, updated on every accepted input word.
	logic [7:0] pat_mem [MAX_LEN];
	int         pat_len = 0;
	logic       pat_lost = 1'b0;
	logic [7:0] sub_mem [MAX_LEN];
	int         sub_len = 0;
	logic       sub_lost = 1'b0;

	// Verdicts still owed by the block, oldest first.
	verdict_t   verdict_q [$];

	int         words_sent = 0;
	int         mismatches = 0;
	int         send_streak = 0;
	int         take_streak = 0;
	int         idle_cycles = 0;

	wildcard_glob_matcher_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.byte_value(byte_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.matched   (matched),
		.overflow  (overflow)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Pattern byte at a position; past the end of the pattern it reads as zero,
	// which never equals a testee byte because zero bytes are never stored.
	function automatic logic [7:0] pat_char(input int i);
		return (i < pat_len) ? pat_mem[i] : 8'h00;
	endfunction

	// Greedy glob match that only ever backtracks to the most recent star.
	// A star in the pattern is always a wildcard, even against a star in the
	// testee.
	function automatic logic glob_verdict();
		int   p = 0;
		int   s = 0;
		int   star_p = 0;
		int   star_s = 0;
		logic have_star = 1'b0;
		while (s < sub_len) begin
			if (pat_char(p) == CH_STAR) begin
				have_star = 1'b1;
				star_p = p;
				star_s = s;
				p++;
			end else if (pat_char(p) == CH_ANY ||
			             (pat_char(p) != 8'h00 && pat_char(p) == sub_mem[s])) begin
				p++;
				s++;
			end else if (have_star) begin
				p = star_p + 1;
				star_s++;
				s = star_s;
			end else begin
				return 1'b0;
			end
		end
		while (pat_char(p) == CH_STAR)
			p++;
		return p >= pat_len;
	endfunction

	// Update the local state for one accepted word and record any verdict.
	function automatic void apply_word(input op_t o, input logic [7:0] b);
		verdict_t v;
		case (o)
			OP_PAT_APPEND: begin
				if (b != 8'h00) begin
					if (pat_len < MAX_LEN) begin
						pat_mem[pat_len] = b;
						pat_len++;
					end else begin
						pat_lost = 1'b1;
					end
				end
			end
			OP_PAT_CLEAR: begin
				pat_len = 0;
				pat_lost = 1'b0;
			end
			OP_SUB_APPEND: begin
				if (b != 8'h00) begin
					if (sub_len < MAX_LEN) begin
						sub_mem[sub_len] = b;
						sub_len++;
					end else begin
						sub_lost = 1'b1;
					end
				end
			end
			default: begin
				v.matched = glob_verdict();
				v.overflow = pat_lost | sub_lost;
				verdict_q.push_back(v);
				sub_len = 0;
				sub_lost = 1'b0;
			end
		endcase
	endfunction

	// Idle cycles before the next word on one side. Now and then a streak of
	// back-to-back words with no idling at all is started.
	function automatic int draw_wait(inout int streak);
		if (streak > 0) begin
			streak--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			streak = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// Mostly the small alphabet that makes matches likely, sometimes any
	// nonzero byte so that every bit of byte_value toggles.
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2: return "a";
			3, 4:    return "b";
			5:       return "c";
			6:       return CH_ANY;
			7:       return CH_STAR;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic int pick_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(MAX_LEN - 2, MAX_LEN + 4);
		return $urandom_range(0, 8);
	endfunction

	// Drive one input word and hold it until it is accepted. Valid stays high
	// when the next word follows without a gap.
	task automatic send_word(input op_t o, input logic [7:0] b);
		int gap;
		gap = draw_wait(send_streak);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		byte_value <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_word(o, b);
		// Zero bytes appended are dropped by the block and are not counted.
		if (!((o == OP_PAT_APPEND || o == OP_SUB_APPEND) && b == 8'h00))
			words_sent++;
	endtask

	// Both stores empty right after reset: the empty pattern matches the
	// empty testee. The byte of a match word is ignored.
	task automatic test_empty_after_reset();
		send_word(OP_MATCH, 8'hFF);
	endtask

	// Extreme byte values, dropped zero bytes, and the ignored byte of a
	// clear word.
	task automatic test_byte_extremes();
		send_word(OP_PAT_APPEND, 8'h00);
		send_word(OP_PAT_APPEND, 8'hFF);
		send_word(OP_SUB_APPEND, 8'h00);
		send_word(OP_SUB_APPEND, 8'hFF);
		send_word(OP_MATCH, 8'h00);
		send_word(OP_SUB_APPEND, 8'h01);
		send_word(OP_MATCH, 8'h00);
		send_word(OP_PAT_CLEAR, 8'hA5);
		send_word(OP_MATCH, 8'h5A);
	endtask

	// Star against a star in the testee, a trailing '?' that has nothing left
	// to consume, and backtracking to the last star.
	task automatic test_wildcards();
		send_word(OP_PAT_APPEND, CH_STAR);
		send_word(OP_PAT_APPEND, CH_ANY);
		send_word(OP_SUB_APPEND, CH_STAR);
		send_word(OP_MATCH, 8'h00);
		send_word(OP_MATCH, 8'h00);
		send_word(OP_PAT_CLEAR, 8'h00);
		send_word(OP_PAT_APPEND, "a");
		send_word(OP_PAT_APPEND, CH_STAR);
		send_word(OP_PAT_APPEND, "b");
		send_word(OP_SUB_APPEND, "a");
		send_word(OP_SUB_APPEND, "b");
		send_word(OP_SUB_APPEND, "a");
		send_word(OP_SUB_APPEND, "b");
		send_word(OP_MATCH, 8'h00);
	endtask

	// Fill both stores past their depth, then check that the overflow flag is
	// reported, also after a match that empties only the testee and after a clear while the testee overflows again.
	task automatic test_store_overflow();
		send_word(OP_PAT_CLEAR, 8'h00);
		repeat (MAX_LEN + 3)
			send_word(OP_PAT_APPEND, pick_char());
		repeat (MAX_LEN + 2)
			send_word(OP_SUB_APPEND, pick_char());
		send_word(OP_MATCH, 8'h00);
		send_word(OP_MATCH, 8'h00);
		send_word(OP_PAT_CLEAR, 8'h00);
		repeat (MAX_LEN + 1)
			send_word(OP_SUB_APPEND, "a");
		send_word(OP_MATCH, 8'h00);
	endtask

	// Random sessions. Most of them load a pattern and then test a few
	// testees, half of which are built from the pattern so that matches are
	// common. The rest is noise: random ops with any byte, zero included.
	task automatic test_random_sessions();
		int   goal;
		int   n;
		logic [7:0] c;
		goal = words_sent + RANDOM_WORDS;
		while (words_sent < goal) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					send_word(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				// Usually a fresh pattern; sometimes the old one is extended.
				if ($urandom_range(0, 3) != 0)
					send_word(OP_PAT_CLEAR, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 4) != 0) begin
					n = pick_len();
					repeat (n)
						send_word(OP_PAT_APPEND, pick_char());
				end
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1) == 0) begin
						for (int i = 0; i < pat_len; i++) begin
							c = pat_mem[i];
							if (c == CH_STAR) begin
								repeat ($urandom_range(0, 3))
									send_word(OP_SUB_APPEND, pick_char());
							end else if (c == CH_ANY || $urandom_range(0, 19) == 0) begin
								send_word(OP_SUB_APPEND, pick_char());
							end else begin
								send_word(OP_SUB_APPEND, c);
							end
						end
					end else begin
						n = pick_len();
						repeat (n)
							send_word(OP_SUB_APPEND, pick_char());
					end
					send_word(OP_MATCH, 8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	// Result side: stall at random, then take one word and compare it with
	// the oldest owed verdict.
	initial begin
		int       stall;
		verdict_t want;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(take_streak);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (verdict_q.size() == 0) begin
				$error("result word with no match op pending: matched %0b overflow %0b",
				       matched, overflow);
				mismatches++;
			end else begin
				want = verdict_q.pop_front();
				if (matched !== want.matched) begin
					$error("matched: expected %0b, got %0b", want.matched, matched);
					mismatches++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, overflow);
					mismatches++;
				end
			end
		end
	end

	// Hang detection: count cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_after_reset();
		test_byte_extremes();
		test_wildcards();
		test_store_overflow();
		test_random_sessions();
		in_valid <= 1'b0;

		// Every match op owes one word; ops 0 to 2 never make the block busy, so a
		// short tail is enough to catch any stray result.
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/gwm_pkg.sv
rtl/wildcard_glob_matcher_core.sv
rtl/gwm_checker.sv
tb/wildcard_glob_matcher_core_test.sv
